### hw/rtl/tss_pkg.sv
// types and constants shared by the thread slot scheduler modules
// no dependencies
package tss_pkg;

  localparam int unsigned TimeW      = 32;
  localparam int unsigned InTdataW   = 24;
  localparam int unsigned InTuserW   = 3;
  localparam int unsigned OutTdataW  = 40;
  localparam int unsigned OutSlotW   = 6;
  localparam int unsigned OutIdxW    = 5;
  localparam int unsigned CharW      = 8;
  localparam int unsigned DurW       = 16;

  typedef enum logic [1:0] {
    ST_EMPTY  = 2'd0,
    ST_READY  = 2'd1,
    ST_SLEEP  = 2'd2,
    ST_WAITCH = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    CMD_TICK    = 3'd0,
    CMD_RESCHED = 3'd1,
    CMD_EXIT    = 3'd2,
    CMD_SLEEP   = 3'd3,
    CMD_GETCHAR = 3'd4,
    CMD_NEW     = 3'd5,
    CMD_KEY     = 3'd6,
    CMD_IGNORE  = 3'd7
  } cmd_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN_A,
    S_SCAN_W,
    S_EMPTY_CHK,
    S_FIND,
    S_FINISH
  } state_e;

  typedef struct packed {
    logic [TimeW-1:0] wake;
    status_e          status;
  } slot_t;

  typedef struct packed {
    logic empty;
    logic ready;
    logic waitch;
    logic woken;
  } eval_t;

  typedef struct packed {
    logic                no_ready;
    logic                all_empty;
    logic [OutIdxW-1:0]  created_slot;
    logic                created_valid;
    logic [CharW-1:0]    deliver_char;
    logic [OutIdxW-1:0]  deliver_slot;
    logic                deliver_valid;
    logic [OutSlotW-1:0] saved_slot;
    logic                switched;
    logic [OutSlotW-1:0] current_slot;
  } out_t;

endpackage

### hw/rtl/thread_slot_scheduler_top.sv
// the slot walk reads one slot per cycle from the slot store through the compare unit
// throughput: one transaction in flight; input is taken again once its result is registered
// reset: all slots empty, no running slot, time and held character zero, no clearing pass
// depends on tss_pkg, tss_slot_store, tss_slot_eval
module thread_slot_scheduler_top #(
  parameter int unsigned SLOTS = 32
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // duration[15:0], char_in[23:16]
  input  logic [tss_pkg::InTdataW-1:0]     s_axis_tdata,
  // command[2:0]
  input  logic [tss_pkg::InTuserW-1:0]     s_axis_tuser,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // current_slot[5:0], switched[6], saved_slot[12:7], deliver_valid[13],
  // deliver_slot[18:14], deliver_char[26:19], created_valid[27],
  // created_slot[32:28], all_empty[33], no_ready[34], zero[39:35]
  output logic [tss_pkg::OutTdataW-1:0]    m_axis_tdata
);
  import tss_pkg::*;

  localparam int unsigned IW = $clog2(SLOTS);
  localparam int unsigned SW = $clog2(SLOTS + 1);
  localparam logic [SW-1:0] NoneSlot = SW'(SLOTS);
  localparam logic [IW-1:0] LastIdx  = IW'(SLOTS - 1);

  state_e            state_q, state_d;
  cmd_e              cmd_in, cmd_q, cmd_d;
  logic [CharW-1:0]  ch_in, ch_q, ch_d;
  logic [DurW-1:0]   dur_in;
  logic [SW-1:0]     running_q, running_d;
  logic [TimeW-1:0]  time_q, time_d;
  logic [CharW-1:0]  held_q, held_d;
  logic [IW-1:0]     ptr_q, ptr_d;
  logic              iss_q, iss_d;
  logic              ev_vld_q, ev_vld_d;
  logic [IW-1:0]     ev_addr_q, ev_addr_d;
  logic              ev_last_q, ev_last_d;
  logic              found_q, found_d;
  logic [IW-1:0]     pick_q, pick_d;
  out_t              res_q, res_d;
  out_t              out_q, out_d;
  logic              out_vld_q, out_vld_d;

  logic              acc;
  logic              have;
  logic [IW-1:0]     run_idx;
  logic              a_empty;
  state_e            scan_entry;
  logic              pass_end;
  logic              w_hit;
  logic              find_hit;
  logic              out_free;
  logic              pass_state_q, pass_state_d;

  logic              st_we;
  logic [IW-1:0]     st_waddr;
  slot_t             st_wdata;
  slot_t             st_rdata;
  eval_t             ev;

  tss_slot_store #(
    .SLOTS(SLOTS)
  ) u_store (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .we_i     (st_we),
    .wr_addr_i(st_waddr),
    .wr_data_i(st_wdata),
    .rd_addr_i(ptr_q),
    .rd_data_o(st_rdata)
  );

  tss_slot_eval u_eval (
    .slot_i (st_rdata),
    .time_i (time_q),
    .flags_o(ev)
  );

  assign cmd_in  = cmd_e'(s_axis_tuser);
  assign dur_in  = s_axis_tdata[DurW-1:0];
  assign ch_in   = s_axis_tdata[DurW+CharW-1:DurW];

  assign s_axis_tready = (state_q == S_IDLE);
  assign acc           = s_axis_tvalid && s_axis_tready;
  assign have          = (running_q != NoneSlot);
  assign run_idx       = running_q[IW-1:0];
  assign a_empty       = have && (run_idx == LastIdx);
  assign scan_entry    = a_empty ? S_SCAN_W : S_SCAN_A;
  assign pass_end      = ev_vld_q && ev_last_q;
  assign w_hit         = ev.ready || ev.woken;
  assign find_hit      = ev_vld_q && ((cmd_q == CMD_NEW) ? ev.empty : ev.waitch);
  assign out_free      = !out_vld_q || m_axis_tready;
  assign pass_state_q  = (state_q == S_SCAN_A) || (state_q == S_SCAN_W) ||
                         (state_q == S_EMPTY_CHK) || (state_q == S_FIND);
  assign pass_state_d  = (state_d == S_SCAN_A) || (state_d == S_SCAN_W) ||
                         (state_d == S_EMPTY_CHK) || (state_d == S_FIND);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (acc) begin
          unique case (cmd_in)
            CMD_TICK, CMD_IGNORE:  state_d = S_FINISH;
            CMD_RESCHED, CMD_SLEEP: state_d = scan_entry;
            CMD_EXIT:              state_d = S_EMPTY_CHK;
            CMD_GETCHAR:           state_d = (have && (held_q != '0)) ? S_FINISH : scan_entry;
            CMD_NEW, CMD_KEY:      state_d = S_FIND;
            default:               state_d = S_FINISH;
          endcase
        end
      end
      S_SCAN_A: begin
        priority if (ev_vld_q && ev.ready) state_d = S_FINISH;
        else if (pass_end)                 state_d = S_SCAN_W;
        else                               state_d = state_q;
      end
      S_SCAN_W: begin
        if (pass_end) state_d = S_FINISH;
      end
      S_EMPTY_CHK: begin
        priority if (ev_vld_q && !ev.empty) state_d = scan_entry;
        else if (pass_end)                  state_d = S_FINISH;
        else                                state_d = state_q;
      end
      S_FIND: begin
        if (find_hit || pass_end) state_d = S_FINISH;
      end
      S_FINISH: begin
        if (out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // datapath and store control
  always_comb begin
    cmd_d     = cmd_q;
    ch_d      = ch_q;
    running_d = running_q;
    time_d    = time_q;
    held_d    = held_q;
    ptr_d     = ptr_q;
    iss_d     = iss_q;
    ev_vld_d  = 1'b0;
    ev_addr_d = ev_addr_q;
    ev_last_d = ev_last_q;
    found_d   = found_q;
    pick_d    = pick_q;
    res_d     = res_q;
    out_d     = out_q;
    out_vld_d = out_vld_q && !m_axis_tready;
    st_we     = 1'b0;
    st_waddr  = run_idx;
    st_wdata  = '{wake: time_q, status: ST_EMPTY};

    // walk pipeline: issue one slot read per cycle
    if (pass_state_q && (state_d == state_q) && iss_q) begin
      ev_vld_d  = 1'b1;
      ev_addr_d = ptr_q;
      ev_last_d = (ptr_q == LastIdx);
      ptr_d     = ptr_q + IW'(1);
      iss_d     = (ptr_q != LastIdx);
    end
    if (pass_state_d && (state_d != state_q)) begin
      iss_d   = 1'b1;
      found_d = 1'b0;
      ptr_d   = (state_d == S_SCAN_A && have) ? (run_idx + IW'(1)) : '0;
    end
    if ((state_d == S_SCAN_A || state_d == S_SCAN_W) &&
        (state_q == S_IDLE || state_q == S_EMPTY_CHK)) begin
      res_d.saved_slot = OutSlotW'(running_q);
    end

    unique case (state_q)
      S_IDLE: begin
        if (acc) begin
          cmd_d            = cmd_in;
          ch_d             = ch_in;
          res_d            = '0;
          res_d.saved_slot = OutSlotW'(NoneSlot);
          if ((state_d == S_SCAN_A || state_d == S_SCAN_W)) begin
            res_d.saved_slot = OutSlotW'(running_q);
          end
          unique case (cmd_in)
            CMD_TICK: time_d = time_q + TimeW'(1);
            CMD_EXIT: begin
              st_we = have;
            end
            CMD_SLEEP: begin
              st_we    = have;
              st_wdata = '{wake: time_q + TimeW'(dur_in), status: ST_SLEEP};
            end
            CMD_GETCHAR: begin
              if (have && (held_q != '0)) begin
                res_d.deliver_valid = 1'b1;
                res_d.deliver_slot  = OutIdxW'(run_idx);
                res_d.deliver_char  = held_q;
                held_d              = '0;
              end else begin
                st_we    = have;
                st_wdata = '{wake: time_q, status: ST_WAITCH};
              end
            end
            default: ;
          endcase
        end
      end
      S_SCAN_A: begin
        if (ev_vld_q && ev.ready) begin
          running_d      = SW'(ev_addr_q);
          res_d.switched = 1'b1;
        end
      end
      S_SCAN_W: begin
        if (ev_vld_q) begin
          if (ev.woken) begin
            st_we    = 1'b1;
            st_waddr = ev_addr_q;
            st_wdata = '{wake: time_q, status: ST_READY};
          end
          if (w_hit && !found_q) begin
            found_d = 1'b1;
            pick_d  = ev_addr_q;
          end
          if (ev_last_q) begin
            if (found_q || w_hit) begin
              running_d      = found_q ? SW'(pick_q) : SW'(ev_addr_q);
              res_d.switched = 1'b1;
            end else begin
              running_d      = NoneSlot;
              res_d.no_ready = 1'b1;
            end
          end
        end
      end
      S_EMPTY_CHK: begin
        if (pass_end && ev.empty) begin
          res_d.all_empty = 1'b1;
          running_d       = NoneSlot;
        end
      end
      S_FIND: begin
        if (find_hit) begin
          st_we    = 1'b1;
          st_waddr = ev_addr_q;
          st_wdata = '{wake: time_q, status: ST_READY};
          if (cmd_q == CMD_NEW) begin
            res_d.created_valid = 1'b1;
            res_d.created_slot  = OutIdxW'(ev_addr_q);
          end else begin
            res_d.deliver_valid = 1'b1;
            res_d.deliver_slot  = OutIdxW'(ev_addr_q);
            res_d.deliver_char  = ch_q;
          end
        end else if (pass_end && (cmd_q == CMD_KEY)) begin
          held_d = ch_q;
        end
      end
      S_FINISH: begin
        if (out_free) begin
          out_d              = res_q;
          out_d.current_slot = OutSlotW'(running_q);
          out_vld_d          = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      running_q <= NoneSlot;
      time_q    <= '0;
      held_q    <= '0;
      iss_q     <= 1'b0;
      ev_vld_q  <= 1'b0;
      found_q   <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      running_q <= running_d;
      time_q    <= time_d;
      held_q    <= held_d;
      iss_q     <= iss_d;
      ev_vld_q  <= ev_vld_d;
      found_q   <= found_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q     <= cmd_d;
    ch_q      <= ch_d;
    ptr_q     <= ptr_d;
    ev_addr_q <= ev_addr_d;
    ev_last_q <= ev_last_d;
    pick_q    <= pick_d;
    res_q     <= res_d;
    out_q     <= out_d;
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {(OutTdataW - $bits(out_t))'(0), out_q};

endmodule

### hw/rtl/tss_ram.sv
// generic single-port-write, single-port-read ram with registered read
// no dependencies
module tss_ram #(
  parameter int unsigned WIDTH = 34,
  parameter int unsigned DEPTH = 32
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### hw/rtl/tss_slot_store.sv
// slot status and wake time store: ram plus per-slot valid bits
// depends on tss_pkg and tss_ram; a slot never written reads as empty
module tss_slot_store #(
  parameter int unsigned SLOTS = 32
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       we_i,
  input  logic [$clog2(SLOTS)-1:0]   wr_addr_i,
  input  tss_pkg::slot_t             wr_data_i,
  input  logic [$clog2(SLOTS)-1:0]   rd_addr_i,
  output tss_pkg::slot_t             rd_data_o
);
  import tss_pkg::*;

  logic [SLOTS-1:0]    vld_q;
  logic                rd_vld_q;
  logic [$bits(slot_t)-1:0] ram_rdata;
  slot_t               ram_slot;

  tss_ram #(
    .WIDTH($bits(slot_t)),
    .DEPTH(SLOTS)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (we_i),
    .waddr_i(wr_addr_i),
    .wdata_i(wr_data_i),
    .raddr_i(rd_addr_i),
    .rdata_o(ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (we_i) begin
        vld_q[wr_addr_i] <= 1'b1;
      end
      rd_vld_q <= vld_q[rd_addr_i];
    end
  end

  always_comb begin
    ram_slot  = slot_t'(ram_rdata);
    rd_data_o = ram_slot;
    if (!rd_vld_q) begin
      rd_data_o.status = ST_EMPTY;
    end
  end

endmodule

### hw/rtl/tss_slot_eval.sv
// shared slot compare unit: classifies one slot and checks its wake time
// depends on tss_pkg
module tss_slot_eval (
  input  tss_pkg::slot_t                slot_i,
  input  logic [tss_pkg::TimeW-1:0]     time_i,
  output tss_pkg::eval_t                flags_o
);
  import tss_pkg::*;

  always_comb begin
    flags_o.empty  = (slot_i.status == ST_EMPTY);
    flags_o.ready  = (slot_i.status == ST_READY);
    flags_o.waitch = (slot_i.status == ST_WAITCH);
    flags_o.woken  = (slot_i.status == ST_SLEEP) && (slot_i.wake <= time_i);
  end

endmodule
